FILE: design/spt_pkg.sv
// Package for the probe tracker: sizes, codes, payload structs and the index hash.
// Used by spt_index and syn_probe_tracker; depends on nothing else.
`default_nettype none
package spt_pkg;
    localparam int PROBE_ENTRIES = 1024;
    localparam int INDEX_SETS    = 512;
    localparam int INDEX_WAYS    = 4;
    localparam int SLOT_W = $clog2(PROBE_ENTRIES);
    localparam int SET_W  = $clog2(INDEX_SETS);
    localparam int WAY_W  = (INDEX_WAYS > 1) ? $clog2(INDEX_WAYS) : 1;
    localparam int CNT_W  = $clog2(PROBE_ENTRIES + 1);

    localparam logic [7:0] VER_IHL_V4 = 8'h45;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_RST_BIT = 2;
    localparam int FLAG_ACK_BIT = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_RESP   = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RC_DONE    = 3'd0,
        RC_FULL    = 3'd1,
        RC_BUCKET  = 3'd2,
        RC_IGNORED = 3'd3,
        RC_NOT_DUE = 3'd4
    } t_code;

    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_FILTERED = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXPIRE
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] target_addr;
        logic [15:0] target_port;
        logic [7:0]  tcp_flags;
        logic [7:0]  ip_proto;
        logic [7:0]  ver_ihl;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [31:0] report_addr;
        logic [15:0] report_port;
        logic [1:0]  report_state;
        logic [10:0] outstanding;
        logic [31:0] open_total;
        logic [31:0] filtered_total;
    } t_out;

    // Result of a lookup in one index set.
    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  hit_way;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [WAY_W-1:0]  free_way;
    } t_lookup;

    // Write request into the index.
    typedef struct packed {
        logic              en;
        logic [SET_W-1:0]  set;
        logic [WAY_W-1:0]  way;
        logic              valid;
        logic [47:0]       key;
        logic [SLOT_W-1:0] slot;
    } t_iwrite;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr,
                                                input logic [15:0] port);
        logic [31:0] h;
        h = addr ^ (addr >> 13) ^ ({16'd0, port} << 7) ^ {16'd0, port};
        return h[SET_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: design/syn_probe_tracker.sv
// Top level of the probe tracker: control, probe ring memory and APB register.
// Depends on spt_pkg and spt_index.
`default_nettype none
// Each transaction reads the index set and probe entry, then writes back; an expire that
// retires a probe also passes through S_EXPIRE, since the retired probe's key is looked up
// in the index after the ring read. Exactly one result strobe follows every transaction,
// and the receiver must take it in that cycle. After reset the index is cleared one set
// per cycle, and busy stays high until that clearing pass ends, so no transaction is accepted.
module syn_probe_tracker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire spt_pkg::t_in  i_item,
    output logic               o_strobe,
    output spt_pkg::t_out      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int SW = spt_pkg::SLOT_W;
    localparam int CW = spt_pkg::CNT_W;

    spt_pkg::t_state r_state, n_state;
    spt_pkg::t_in    r_item;
    logic [7:0]      r_timeout;
    logic [SW-1:0]   r_head, r_tail;
    logic [CW-1:0]   r_held, n_held;
    logic [31:0]     r_open, r_filt, n_open, n_filt;
    logic            n_strobe;
    spt_pkg::t_out   n_result;

    // Probe ring: {addr, port, start} and status in separate memories.
    logic [79:0]   ring_mem [spt_pkg::PROBE_ENTRIES];
    logic [1:0]    stat_mem [spt_pkg::PROBE_ENTRIES];
    logic [79:0]   r_ring;
    logic [1:0]    r_stat;
    logic          ring_we, stat_we;
    logic [SW-1:0] stat_wa;
    logic [1:0]    stat_wd;

    logic [spt_pkg::SET_W-1:0] rd_set;
    logic [47:0]               rd_key;
    spt_pkg::t_iwrite          iwr;
    spt_pkg::t_lookup          lk;
    logic                      idx_clearing;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != spt_pkg::S_IDLE) || idx_clearing;
    assign pready = 1'b1;
    assign prdata = (paddr == spt_pkg::REG_TIMEOUT) ? {24'd0, r_timeout} : 32'd0;

    always_comb begin
        if (r_state == spt_pkg::S_LOOKUP) begin
            rd_set = spt_pkg::set_of(r_ring[79:48], r_ring[47:32]);
            rd_key = {r_ring[47:32], r_ring[79:48]};
        end else begin
            rd_set = spt_pkg::set_of(i_item.target_addr, i_item.target_port);
            rd_key = {i_item.target_port, i_item.target_addr};
        end
    end

    spt_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_set   (rd_set),
        .i_rd_key   (rd_key),
        .i_wr       (iwr),
        .o_lookup   (lk),
        .o_clearing (idx_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_tail] <= {r_item.target_addr, r_item.target_port, r_item.now_seconds};
        end
        if (stat_we) begin
            stat_mem[stat_wa] <= stat_wd;
        end
        r_ring <= ring_mem[r_head];
        r_stat <= stat_mem[r_head];
    end

    always_comb begin
        logic        is_open, is_filt, due;
        logic [32:0] deadline;
        n_state  = r_state;
        n_strobe = 1'b0;
        n_held   = r_held;
        n_open   = r_open;
        n_filt   = r_filt;
        ring_we  = 1'b0;
        stat_we  = 1'b0;
        stat_wa  = r_tail;
        stat_wd  = spt_pkg::ST_UNKNOWN;
        iwr      = '0;
        iwr.set  = spt_pkg::set_of(r_item.target_addr, r_item.target_port);
        iwr.key  = {r_item.target_port, r_item.target_addr};
        iwr.slot = r_tail;
        n_result = '0;
        n_result.result_code = spt_pkg::RC_IGNORED;
        is_open = r_item.tcp_flags[spt_pkg::FLAG_SYN_BIT] && r_item.tcp_flags[spt_pkg::FLAG_ACK_BIT];
        is_filt = r_item.tcp_flags[spt_pkg::FLAG_RST_BIT];
        deadline = {1'b0, r_ring[31:0]} + {25'd0, r_timeout};
        due = (r_held != '0) && (deadline < {1'b0, r_item.now_seconds});
        case (r_state)
            spt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = spt_pkg::S_LOOKUP;
                end
            end
            spt_pkg::S_LOOKUP: begin
                n_state = spt_pkg::S_IDLE;
                n_strobe = 1'b1;
                case (r_item.op)
                    spt_pkg::OP_ADD: begin
                        if (r_held >= CW'(spt_pkg::PROBE_ENTRIES)) begin
                            n_result.result_code = spt_pkg::RC_FULL;
                        end else if (!lk.hit && !lk.free) begin
                            n_result.result_code = spt_pkg::RC_BUCKET;
                        end else begin
                            n_result.result_code = spt_pkg::RC_DONE;
                            ring_we = 1'b1;
                            stat_we = 1'b1;
                            iwr.en = 1'b1;
                            iwr.valid = 1'b1;
                            iwr.way = lk.hit ? lk.hit_way : lk.free_way;
                            n_held = r_held + 1'b1;
                        end
                    end
                    spt_pkg::OP_RESP: begin
                        if (r_item.ip_proto == spt_pkg::PROTO_TCP
                                && r_item.ver_ihl == spt_pkg::VER_IHL_V4
                                && (is_open || is_filt) && lk.hit) begin
                            n_result.result_code = spt_pkg::RC_DONE;
                            stat_we = 1'b1;
                            stat_wa = lk.hit_slot;
                            stat_wd = is_open ? spt_pkg::ST_OPEN : spt_pkg::ST_FILTERED;
                        end
                    end
                    spt_pkg::OP_EXPIRE: begin
                        if (due) begin
                            n_strobe = 1'b0;
                            n_state = spt_pkg::S_EXPIRE;
                        end else begin
                            n_result.result_code = spt_pkg::RC_NOT_DUE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            spt_pkg::S_EXPIRE: begin
                n_state = spt_pkg::S_IDLE;
                n_strobe = 1'b1;
                n_result.result_code = spt_pkg::RC_DONE;
                n_result.report_addr = r_ring[79:48];
                n_result.report_port = r_ring[47:32];
                n_result.report_state = r_stat;
                if (r_stat == spt_pkg::ST_OPEN) begin
                    n_open = r_open + 32'd1;
                end else if (r_stat == spt_pkg::ST_FILTERED) begin
                    n_filt = r_filt + 32'd1;
                end
                if (lk.hit && lk.hit_slot == r_head) begin
                    iwr.en = 1'b1;
                    iwr.valid = 1'b0;
                    iwr.set = spt_pkg::set_of(r_ring[79:48], r_ring[47:32]);
                    iwr.way = lk.hit_way;
                end
                n_held = r_held - 1'b1;
            end
            default: begin
                n_state = spt_pkg::S_IDLE;
            end
        endcase
        n_result.outstanding    = 11'(n_held);
        n_result.open_total     = n_open;
        n_result.filtered_total = n_filt;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        o_result <= n_result;
        if (!i_rst_n) begin
            r_state   <= spt_pkg::S_IDLE;
            o_strobe  <= 1'b0;
            r_timeout <= 8'd10;
            r_head    <= '0;
            r_tail    <= '0;
            r_held    <= '0;
            r_open    <= '0;
            r_filt    <= '0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
            r_held   <= n_held;
            r_open   <= n_open;
            r_filt   <= n_filt;
            if (ring_we) begin
                r_tail <= r_tail + 1'b1;
            end
            if (r_state == spt_pkg::S_EXPIRE) begin
                r_head <= r_head + 1'b1;
            end
            if (psel && penable && pwrite && paddr == spt_pkg::REG_TIMEOUT) begin
                r_timeout <= pwdata[7:0];
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/spt_index.sv
// Set-associative key index: one memory row per set holding valid bit, key and slot per way.
// A clearing pass after reset empties every set. Depends on spt_pkg.
`default_nettype none
module spt_index (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [spt_pkg::SET_W-1:0] i_rd_set,
    input  wire logic [47:0]               i_rd_key,
    input  wire spt_pkg::t_iwrite          i_wr,
    output spt_pkg::t_lookup               o_lookup,
    output logic                           o_clearing
);
    localparam int W = spt_pkg::INDEX_WAYS;
    localparam int ROW_W = 1 + 48 + spt_pkg::SLOT_W;

    logic [W*ROW_W-1:0]        mem [spt_pkg::INDEX_SETS];
    logic [W*ROW_W-1:0]        r_row;
    logic [47:0]               r_key;
    logic                      r_clear;
    logic [spt_pkg::SET_W-1:0] r_clear_set;
    logic [W*ROW_W-1:0]        n_row;
    logic                      wr_en;
    logic [spt_pkg::SET_W-1:0] wr_set;
    logic [W*ROW_W-1:0]        wr_row;

    assign o_clearing = r_clear;

    always_comb begin
        n_row = r_row;
        n_row[i_wr.way*ROW_W +: ROW_W] = {i_wr.valid, i_wr.key, i_wr.slot};
        wr_en  = r_clear || i_wr.en;
        wr_set = r_clear ? r_clear_set : i_wr.set;
        wr_row = r_clear ? '0 : n_row;
    end

    // The caller writes a set only after it has read it, so the read row is current.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_set] <= wr_row;
        end
        r_row <= mem[i_rd_set];
        r_key <= i_rd_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear     <= 1'b1;
            r_clear_set <= '0;
        end else if (r_clear) begin
            r_clear_set <= r_clear_set + 1'b1;
            if (r_clear_set == spt_pkg::SET_W'(spt_pkg::INDEX_SETS - 1)) begin
                r_clear <= 1'b0;
            end
        end
    end

    always_comb begin
        o_lookup = '0;
        for (int w = W - 1; w >= 0; w--) begin
            if (!r_row[w*ROW_W + ROW_W - 1]) begin
                o_lookup.free     = 1'b1;
                o_lookup.free_way = spt_pkg::WAY_W'(w);
            end
        end
        for (int w = W - 1; w >= 0; w--) begin
            if (r_row[w*ROW_W + ROW_W - 1]
                    && r_row[w*ROW_W+spt_pkg::SLOT_W +: 48] == r_key) begin
                o_lookup.hit      = 1'b1;
                o_lookup.hit_way  = spt_pkg::WAY_W'(w);
                o_lookup.hit_slot = r_row[w*ROW_W +: spt_pkg::SLOT_W];
            end
        end
    end
endmodule
`default_nettype wire
